/* hdl/buddy_block_allocator_macros.svh */
// assertion macros for the buddy block allocator
// used by the rtl files that carry concurrent checks
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// check on an explicit clock and active-low reset
`define BBA_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bba assertion failed");

// check on the module's own clk_i and rst_ni
`define BBA_ASSERT(lbl, prop) `BBA_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

/* hdl/bba_pkg.sv */
// shared types and constants of the buddy block allocator
// no dependencies
`default_nettype none

package bba_pkg;

  localparam int unsigned DefLog2PoolUnits = 10;
  localparam int unsigned DefOwnerCount    = 256;
  localparam int unsigned LvlW             = 5;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef logic [LvlW-1:0] lvl_t;

  typedef struct packed {
    logic        command;
    logic [7:0]  owner_id;
    logic [11:0] request_size;
  } bba_req_t;

  typedef struct packed {
    logic        ok;
    logic [10:0] granted_size;
    logic [9:0]  block_start;
  } bba_rsp_t;

  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_FREE,
    KIND_REJECT
  } bba_kind_e;

  // classified command handed from front to back
  typedef struct packed {
    bba_kind_e  kind;
    logic [7:0] owner_id;
    lvl_t       want;
  } bba_job_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_ROOT,
    ST_A_NODE,
    ST_A_KIDS,
    ST_A_FAIL,
    ST_A_SIB,
    ST_A_MARK,
    ST_F_LOOK,
    ST_F_READ,
    ST_F_UPD,
    ST_RESP
  } bba_state_e;

endpackage

`default_nettype wire

/* hdl/bba_fifo.sv */
// two-entry queue of classified commands between front and back
// depends on bba_pkg
`default_nettype none

module bba_fifo
  import bba_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire bba_job_t push_data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output bba_job_t      head_o,
  output logic          head_valid_o
);

  bba_job_t   ent_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_data_i;
    end
  end

  assign full_o       = cnt_q[1];
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = ent_q[rd_q];

endmodule

`default_nettype wire

/* hdl/bba_front.sv */
// front end: accepts commands, checks owner and size, rounds size to a level
// depends on bba_pkg and bba_fifo
`default_nettype none

module bba_front
  import bba_pkg::*;
#(
  parameter int unsigned Log2PoolUnits = DefLog2PoolUnits,
  parameter int unsigned OwnerCount    = DefOwnerCount
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  output logic          req_ready_o,
  input  wire bba_req_t req_i,
  input  wire logic     pop_i,
  output bba_job_t      job_o,
  output logic          job_valid_o
);

  bba_job_t job;
  logic     full;
  logic     push;
  logic     size_bad;

  always_comb begin
    job          = '0;
    job.owner_id = req_i.owner_id;
    job.want     = lvl_t'(Log2PoolUnits);
    // smallest level whose block holds the request
    for (int k = int'(Log2PoolUnits) - 1; k >= 0; k--) begin
      if (32'(req_i.request_size) <= (32'd1 << k)) begin
        job.want = lvl_t'(k);
      end
    end
    size_bad = (req_i.request_size == 12'd0) ||
               (32'(req_i.request_size) > (32'd1 << Log2PoolUnits));
    if (32'(req_i.owner_id) >= OwnerCount) begin
      job.kind = KIND_REJECT;
    end else if (req_i.command == CMD_FREE) begin
      job.kind = KIND_FREE;
    end else if (size_bad) begin
      job.kind = KIND_REJECT;
    end else begin
      job.kind = KIND_ALLOC;
    end
  end

  assign req_ready_o = !full;
  assign push        = req_valid_i && !full;

  bba_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (job),
    .full_o      (full),
    .pop_i       (pop_i),
    .head_o      (job_o),
    .head_valid_o(job_valid_o)
  );

endmodule

`default_nettype wire

/* hdl/bba_back.sv */
// back end: tree search, marking, freeing, owner records and result register
// depends on bba_pkg and buddy_block_allocator_macros.svh
`default_nettype none
`include "buddy_block_allocator_macros.svh"

module bba_back
  import bba_pkg::*;
#(
  parameter int unsigned Log2PoolUnits = DefLog2PoolUnits,
  parameter int unsigned OwnerCount    = DefOwnerCount
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     job_valid_i,
  input  wire bba_job_t job_i,
  output logic          job_pop_o,
  output logic          rsp_valid_o,
  input  wire logic     rsp_ready_i,
  output bba_rsp_t      rsp_o
);

  localparam int unsigned L          = Log2PoolUnits;
  localparam int unsigned TreeRows   = 2 ** L;
  localparam int unsigned OwnerSlots = (OwnerCount < 256) ? OwnerCount : 256;
  localparam int unsigned OwnIdxW    = $clog2(OwnerSlots);

  typedef logic [L:0]   node_t;
  typedef logic [L-1:0] unit_t;

  // row r holds nodes 2r and 2r+1: {htb1, taken1, htb0, taken0}
  logic [3:0] tree_mem [TreeRows];
  logic [3:0] tree_rdata_q;
  logic [3:0] tree_we;
  logic [3:0] tree_wdata;
  unit_t      tree_waddr;
  unit_t      tree_raddr;

  unit_t      own_start_mem [OwnerSlots];
  lvl_t       own_lvl_mem   [OwnerSlots];
  unit_t      own_start_q;
  lvl_t       own_lvl_q;
  logic       own_we;
  logic [OwnIdxW-1:0] own_raddr;
  logic [OwnerSlots-1:0] owner_valid_q;
  logic       ownv_set, ownv_clr;

  bba_state_e state_q, state_d;
  node_t      node_q, node_d;
  lvl_t       lvl_q, lvl_d;
  lvl_t       want_q, want_d;
  unit_t      start_q, start_d;
  logic [1:0] cur_q, cur_d;
  logic [31:0] second_q, second_d;
  logic [OwnIdxW-1:0] owner_q, owner_d;
  bba_rsp_t   res_q, res_d;
  logic       out_valid_q, out_valid_d;
  bba_rsp_t   out_q, out_d;

  logic       slot;
  logic [1:0] kid0, kid1;
  logic       swap;
  lvl_t       plvl;
  lvl_t       flvl;
  node_t      fnode;
  logic       out_space;

  always_comb begin
    slot      = node_q[0];
    kid0      = tree_rdata_q[1:0];
    kid1      = tree_rdata_q[3:2];
    swap      = kid1[1] && !kid0[1];
    plvl      = lvl_q + lvl_t'(1);
    flvl      = (own_lvl_q > lvl_t'(L)) ? lvl_t'(L) : own_lvl_q;
    fnode     = (node_t'(1) << (lvl_t'(L) - flvl)) + node_t'(own_start_q >> flvl);
    out_space = !out_valid_q || rsp_ready_i;
    own_raddr = job_i.owner_id[OwnIdxW-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (node_q[L-1:0] == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (job_valid_i) begin
          unique case (job_i.kind)
            KIND_ALLOC: state_d = ST_A_ROOT;
            KIND_FREE: begin
              state_d = owner_valid_q[own_raddr] ? ST_F_LOOK : ST_RESP;
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_A_ROOT: state_d = ST_A_NODE;
      ST_A_NODE: begin
        if (cur_q[0]) begin
          state_d = ST_A_FAIL;
        end else if (lvl_q == want_q) begin
          state_d = cur_q[1] ? ST_A_FAIL : ST_A_MARK;
        end else begin
          state_d = ST_A_KIDS;
        end
      end
      ST_A_KIDS: state_d = ST_A_NODE;
      ST_A_FAIL: begin
        if (lvl_q == lvl_t'(L)) begin
          state_d = ST_RESP;
        end else if (!second_q[plvl]) begin
          state_d = ST_A_SIB;
        end
      end
      ST_A_SIB: state_d = ST_A_NODE;
      ST_A_MARK: begin
        if (node_q == '0) state_d = ST_RESP;
      end
      ST_F_LOOK: begin
        state_d = (fnode[L:1] == '0) ? ST_RESP : ST_F_READ;
      end
      ST_F_READ: state_d = ST_F_UPD;
      ST_F_UPD: begin
        state_d = (node_q[L:1] == '0) ? ST_RESP : ST_F_READ;
      end
      ST_RESP: begin
        if (out_space) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    node_d      = node_q;
    lvl_d       = lvl_q;
    want_d      = want_q;
    start_d     = start_q;
    cur_d       = cur_q;
    second_d    = second_q;
    owner_d     = owner_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    out_d       = out_q;
    tree_we     = 4'b0000;
    tree_wdata  = 4'b0000;
    tree_waddr  = node_q[L:1];
    tree_raddr  = '0;
    own_we      = 1'b0;
    ownv_set    = 1'b0;
    ownv_clr    = 1'b0;
    job_pop_o   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        tree_we    = 4'b1111;
        tree_waddr = node_q[L-1:0];
        node_d     = node_q + node_t'(1);
      end
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          owner_d   = own_raddr;
          want_d    = job_i.want;
          node_d    = node_t'(1);
          lvl_d     = lvl_t'(L);
          start_d   = '0;
          second_d  = '0;
          res_d     = '0;
        end
      end
      ST_A_ROOT: begin
        cur_d = kid1;
      end
      ST_A_NODE: begin
        if (!cur_q[0] && lvl_q == want_q && !cur_q[1]) begin
          tree_we   = slot ? 4'b0100 : 4'b0001;
          tree_wdata = 4'b0101;
          own_we    = 1'b1;
          ownv_set  = 1'b1;
          res_d.ok  = 1'b1;
          res_d.granted_size = 11'(32'd1 << want_q);
          res_d.block_start  = 10'(32'(start_q));
          node_d    = node_q >> 1;
        end else if (!cur_q[0] && lvl_q != want_q) begin
          tree_raddr = node_q[L-1:0];
        end
      end
      ST_A_KIDS: begin
        second_d[lvl_q] = 1'b0;
        node_d  = {node_q[L-1:0], swap};
        lvl_d   = lvl_q - lvl_t'(1);
        start_d = swap ? (start_q | (unit_t'(1) << (lvl_q - lvl_t'(1)))) : start_q;
        cur_d   = swap ? kid1 : kid0;
      end
      ST_A_FAIL: begin
        if (lvl_q != lvl_t'(L)) begin
          if (!second_q[plvl]) begin
            second_d[plvl] = 1'b1;
            tree_raddr     = node_q[L:1];
          end else begin
            node_d  = node_q >> 1;
            lvl_d   = plvl;
            start_d = start_q & (unit_t'('1) << plvl);
          end
        end
      end
      ST_A_SIB: begin
        node_d  = node_q ^ node_t'(1);
        start_d = start_q ^ (unit_t'(1) << lvl_q);
        cur_d   = slot ? kid0 : kid1;
      end
      ST_A_MARK: begin
        // ancestors on the search path now have a taken node below
        if (node_q != '0) begin
          tree_we    = slot ? 4'b1000 : 4'b0010;
          tree_wdata = 4'b1010;
          node_d     = node_q >> 1;
        end
      end
      ST_F_LOOK: begin
        tree_waddr = fnode[L:1];
        tree_we    = fnode[0] ? 4'b1100 : 4'b0011;
        tree_wdata = 4'b0000;
        ownv_clr   = 1'b1;
        node_d     = fnode >> 1;
        res_d.ok   = 1'b1;
        res_d.block_start = 10'(32'(own_start_q));
      end
      ST_F_READ: begin
        tree_raddr = node_q[L-1:0];
      end
      ST_F_UPD: begin
        tree_we    = slot ? 4'b1000 : 4'b0010;
        tree_wdata = {4{|tree_rdata_q}};
        node_d     = node_q >> 1;
      end
      ST_RESP: begin
        if (out_space) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      node_q        <= '0;
      second_q      <= '0;
      out_valid_q   <= 1'b0;
      owner_valid_q <= '0;
    end else begin
      state_q     <= state_d;
      node_q      <= node_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
      if (ownv_set) owner_valid_q[owner_q] <= 1'b1;
      if (ownv_clr) owner_valid_q[owner_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q   <= lvl_d;
    want_q  <= want_d;
    start_q <= start_d;
    cur_q   <= cur_d;
    owner_q <= owner_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  // tree memory with per-bit write enables
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 4; b++) begin
      if (tree_we[b]) tree_mem[tree_waddr][b] <= tree_wdata[b];
    end
    tree_rdata_q <= tree_mem[tree_raddr];
  end

  // owner record memory
  always_ff @(posedge clk_i) begin
    if (own_we) begin
      own_start_mem[owner_q] <= start_q;
      own_lvl_mem[owner_q]   <= want_q;
    end
    own_start_q <= own_start_mem[own_raddr];
    own_lvl_q   <= own_lvl_mem[own_raddr];
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  `BBA_ASSERT(a_no_tree_write_idle, (state_q == ST_IDLE || state_q == ST_RESP) |-> (tree_we == 4'b0000))
  `BBA_ASSERT(a_search_floor, (state_q == ST_A_NODE) |-> (lvl_q >= want_q))
  `BBA_ASSERT(a_resp_loads, (state_q == ST_RESP && out_space) |=> out_valid_q)

endmodule

`default_nettype wire

/* hdl/buddy_block_allocator.sv */
// Buddy allocator over a pool of 2**Log2PoolUnits units, kept as a heap-ordered tree of
// taken and has-taken-below bits in a one-read one-write memory of node pairs. Commands
// enter a front stage that checks owner and size and rounds the size to a level, and wait
// in a two-entry queue for the back end. After reset a clearing pass writes every row of
// the tree memory (2**Log2PoolUnits rows, 1024 by default) before the first command is
// taken. An allocate walks the tree depth first, reading the children of each node it
// steps into and of each sibling it backtracks to and climbing a level when both fail,
// then sets the has-taken-below bit of each ancestor on the path. A free clears the
// owner's block and rewrites each ancestor up to the root from a read of its children;
// a rejected command goes straight to the result. One result per command.
// depends on bba_pkg, bba_front and bba_back
`default_nettype none

module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned Log2PoolUnits = DefLog2PoolUnits,
  parameter int unsigned OwnerCount    = DefOwnerCount
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  output logic          req_ready_o,
  input  wire bba_req_t req_data_i,
  output logic          rsp_valid_o,
  input  wire logic     rsp_ready_i,
  output bba_rsp_t      rsp_data_o
);

  bba_job_t job;
  logic     job_valid;
  logic     job_pop;

  bba_front #(
    .Log2PoolUnits(Log2PoolUnits),
    .OwnerCount   (OwnerCount)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_data_i),
    .pop_i      (job_pop),
    .job_o      (job),
    .job_valid_o(job_valid)
  );

  bba_back #(
    .Log2PoolUnits(Log2PoolUnits),
    .OwnerCount   (OwnerCount)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job),
    .job_pop_o  (job_pop),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_data_o)
  );

endmodule

`default_nettype wire
